// ===== hdl/tlik_pkg.sv =====
`timescale 1ns / 1ps

package tlik_pkg;

    // default geometry of the block
    localparam int COORD_WIDTH_DEF   = 20;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // link lengths after reset, Q15.4
    localparam int FIRST_LINK_RESET  = 2800;
    localparam int SECOND_LINK_RESET = 2000;

    // apb register file
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic
    {
        REG_FIRST_LINK  = 1'b0,
        REG_SECOND_LINK = 1'b1
    } reg_idx_t;

    // cordic datapath: operands below 2^31, growth below 2.33
    localparam int CORDIC_W  = 35;
    localparam int NORM_BITS = 31;
    localparam int TURN_W    = 32;
    localparam logic [TURN_W-1:0] HALF_TURN = 32'h8000_0000;

    // atan(2^-i) in units of 2^-32 turn
    localparam int ATAN_LEN = 24;
    localparam logic [TURN_W-1:0] ATAN_TABLE [0:ATAN_LEN-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

// ===== hdl/tlik_if.sv =====
`timescale 1ns / 1ps

interface tlik_in_if #(
    parameter int CW = tlik_pkg::COORD_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] target_x;
    logic signed [CW-1:0] target_y;

    modport source (output valid, output target_x, output target_y, input ready);
    modport sink   (input valid, input target_x, input target_y, output ready);
endinterface

interface tlik_out_if #(
    parameter int AW = tlik_pkg::ANGLE_WIDTH_DEF
);
    logic          valid;
    logic          ready;
    logic [AW-1:0] shoulder_angle;
    logic [AW-1:0] elbow_angle;
    logic          unreachable;

    modport source (output valid, output shoulder_angle, output elbow_angle,
                    output unreachable, input ready);
    modport sink   (input valid, input shoulder_angle, input elbow_angle,
                    input unreachable, output ready);
endinterface

// ===== hdl/tlik_sqrt_cell.sv =====
`timescale 1ns / 1ps

// one result bit of the integer square root per cell
module tlik_sqrt_cell #(
    parameter int SW = 40,
    parameter int DW = 80,
    parameter int RW = 43
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] rad_in,
    input  logic [RW-1:0] rem_in,
    input  logic [SW-1:0] root_in,
    output logic [DW-1:0] rad_out,
    output logic [RW-1:0] rem_out,
    output logic [SW-1:0] root_out
);

    logic [RW-1:0] rem_cat;
    logic [RW-1:0] trial;
    logic          fits;

    always_comb
    begin
        rem_cat = {rem_in[RW-3:0], rad_in[DW-1 -: 2]};
        trial   = RW'({root_in, 2'b01});
        fits    = (rem_cat >= trial);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_out  <= {rad_in[DW-3:0], 2'b00};
            rem_out  <= fits ? (rem_cat - trial) : rem_cat;
            root_out <= {root_in[SW-2:0], fits};
        end
    end

endmodule

// ===== hdl/tlik_norm_cell.sv =====
`timescale 1ns / 1ps

// halves a (sine, cosine) pair while either term is at or above 2^LIM
module tlik_norm_cell #(
    parameter int SW  = 40,
    parameter int LIM = 31
) (
    input  logic          clk,
    input  logic          en,
    input  logic [SW-1:0] sa_in,
    input  logic [SW-1:0] pa_in,
    input  logic [SW-1:0] sb_in,
    input  logic [SW-1:0] pb_in,
    output logic [SW-1:0] sa_out,
    output logic [SW-1:0] pa_out,
    output logic [SW-1:0] sb_out,
    output logic [SW-1:0] pb_out
);

    logic big_a;
    logic big_b;

    always_comb
    begin
        big_a = |(sa_in[SW-1:LIM] | pa_in[SW-1:LIM]);
        big_b = |(sb_in[SW-1:LIM] | pb_in[SW-1:LIM]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_out <= big_a ? (sa_in >> 1) : sa_in;
            pa_out <= big_a ? (pa_in >> 1) : pa_in;
            sb_out <= big_b ? (sb_in >> 1) : sb_in;
            pb_out <= big_b ? (pb_in >> 1) : pb_in;
        end
    end

endmodule

// ===== hdl/tlik_cordic_cell.sv =====
`timescale 1ns / 1ps

// one vectoring micro-rotation, drives y toward zero
module tlik_cordic_cell #(
    parameter int XW  = tlik_pkg::CORDIC_W,
    parameter int IDX = 0
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [XW-1:0]          x_in,
    input  logic signed [XW-1:0]          y_in,
    input  logic [tlik_pkg::TURN_W-1:0]   acc_in,
    output logic signed [XW-1:0]          x_out,
    output logic signed [XW-1:0]          y_out,
    output logic [tlik_pkg::TURN_W-1:0]   acc_out
);

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    always_comb
    begin
        dx = y_in >>> IDX;
        dy = x_in >>> IDX;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (y_in > 0)
            begin
                x_out   <= x_in + dx;
                y_out   <= y_in - dy;
                acc_out <= acc_in + tlik_pkg::ATAN_TABLE[IDX];
            end
            else
            begin
                x_out   <= x_in - dx;
                y_out   <= y_in + dy;
                acc_out <= acc_in - tlik_pkg::ATAN_TABLE[IDX];
            end
        end
    end

endmodule

// ===== hdl/two_link_inverse_kinematics.sv =====
`timescale 1ns / 1ps

// two-link planar inverse kinematics. a target (target_x, target_y) in signed
// Q15.4 goes in, the shoulder and elbow joint angles come out as binary angles
// (2^ANGLE_WIDTH is one turn) with the law of cosines, evaluated exactly in
// integers: base angle atan2(y,x), alpha = atan2(S,P), beta = atan2(S,Q) with
// S the integer square root of 16*area^2 of the arm triangle. the block is a
// fully pipelined row of cells and takes one transfer every clock cycle while
// the output is not stalled. it holds one square-root cell per root bit, one
// normalizing cell per excess magnitude bit and one cordic cell per rotation.
// a stalled output holds the whole row, and a new target is taken whenever
// the output register is empty or being drained. a target at the origin, a
// zero link length or a point out of reach gives unreachable = 1 and zero
// angles. link lengths sit in two apb registers (byte addresses 0 and 4,
// decoded on paddr[2]); write them only while the pipeline is empty.
module two_link_inverse_kinematics #(
    parameter int COORD_WIDTH   = tlik_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = tlik_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = tlik_pkg::CORDIC_STAGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tlik_in_if.sink                         target,
    tlik_out_if.source                      joints,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tlik_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tlik_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tlik_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int CW = COORD_WIDTH;
    localparam int LW = CW - 1;                 // link length bits
    localparam int BW = 2 * CW;                 // squared distance
    localparam int SW = 2 * CW;                 // root and cosine terms
    localparam int DW = 4 * CW;                 // 16 * area^2
    localparam int RW = SW + 3;                 // root remainder
    localparam int NB = tlik_pkg::NORM_BITS;
    localparam int NN = (SW > NB) ? (SW - NB) : 0;
    localparam int NC = CORDIC_STAGES;
    localparam int XW = tlik_pkg::CORDIC_W;
    localparam int TW = tlik_pkg::TURN_W;
    localparam int AW = ANGLE_WIDTH;

    localparam logic [LW-1:0] FIRST_RST  = LW'(tlik_pkg::FIRST_LINK_RESET);
    localparam logic [LW-1:0] SECOND_RST = LW'(tlik_pkg::SECOND_LINK_RESET);
    localparam logic [TW-1:0] ROUND_HALF = TW'(1) << (TW - 1 - AW);

    // everything the root and normalizer stages hand along
    typedef struct packed {
        logic                 unreach;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [SW-1:0]        pmag;
        logic                 pneg;
        logic [SW-1:0]        qmag;
        logic                 qneg;
    } side_t;

    typedef struct packed {
        logic                 unreach;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 pneg;
        logic                 qneg;
    } nside_t;

    // the whole row moves together; it stops only while a result waits
    logic adv;
    logic out_valid_reg;

    assign adv          = !out_valid_reg || joints.ready;
    assign target.ready = adv;

    // ------------------------------------------------------------------
    // link length registers and their squares
    // ------------------------------------------------------------------
    logic [LW-1:0]   first_link_reg;
    logic [LW-1:0]   second_link_reg;
    logic [2*LW-1:0] cc_reg;                    // first link squared
    logic [2*LW-1:0] aa_reg;                    // second link squared
    logic            link_zero_reg;
    logic            apb_write;

    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_link_reg  <= FIRST_RST;
            second_link_reg <= SECOND_RST;
            cc_reg          <= (2*LW)'(FIRST_RST) * (2*LW)'(FIRST_RST);
            aa_reg          <= (2*LW)'(SECOND_RST) * (2*LW)'(SECOND_RST);
            link_zero_reg   <= (FIRST_RST == '0) || (SECOND_RST == '0);
        end
        else
        begin
            if (apb_write)
            begin
                case (tlik_pkg::reg_idx_t'(paddr[2]))
                    tlik_pkg::REG_FIRST_LINK:  first_link_reg  <= pwdata[LW-1:0];
                    tlik_pkg::REG_SECOND_LINK: second_link_reg <= pwdata[LW-1:0];
                    default: ;
                endcase
            end
            // squares follow the registers in the next cycle
            cc_reg        <= (2*LW)'(first_link_reg) * (2*LW)'(first_link_reg);
            aa_reg        <= (2*LW)'(second_link_reg) * (2*LW)'(second_link_reg);
            link_zero_reg <= (first_link_reg == '0) || (second_link_reg == '0);
        end
    end

    always_comb
    begin
        case (tlik_pkg::reg_idx_t'(paddr[2]))
            tlik_pkg::REG_FIRST_LINK:  prdata = tlik_pkg::APB_DATA_W'(first_link_reg);
            tlik_pkg::REG_SECOND_LINK: prdata = tlik_pkg::APB_DATA_W'(second_link_reg);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // front end: squares, cosine terms and the area test
    // ------------------------------------------------------------------
    logic                 v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [CW-1:0] x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    logic [BW-1:0]        sqx1_reg, sqy1_reg, bb2_reg, bb3_reg;
    side_t                sd3_reg, sd4_reg, sd5_reg;
    logic [3*CW-3:0]      m0_reg, m1_reg;       // bb * cc halves
    logic [3*CW-1:0]      n0_reg, n1_reg;       // p * p halves
    logic [DW-1:0]        four5_reg, p2_5_reg;

    logic [CW-1:0] ax0, ay0;
    logic [BW-1:0] pos_p, pos_q, aa_ext, cc_ext;
    side_t         sd3_next;
    logic [DW-1:0] four_next, p2_next;

    always_comb
    begin
        ax0 = x0_reg[CW-1] ? CW'(-x0_reg) : CW'(x0_reg);
        ay0 = y0_reg[CW-1] ? CW'(-y0_reg) : CW'(y0_reg);

        aa_ext = BW'(aa_reg);
        cc_ext = BW'(cc_reg);
        pos_p  = bb2_reg + cc_ext;
        pos_q  = bb2_reg + aa_ext;

        sd3_next.unreach = (bb2_reg == '0) || link_zero_reg;
        sd3_next.x       = x2_reg;
        sd3_next.y       = y2_reg;
        sd3_next.pneg    = pos_p < aa_ext;
        sd3_next.pmag    = sd3_next.pneg ? (aa_ext - pos_p) : (pos_p - aa_ext);
        sd3_next.qneg    = pos_q < cc_ext;
        sd3_next.qmag    = sd3_next.qneg ? (cc_ext - pos_q) : (pos_q - cc_ext);

        four_next = ((DW'(m1_reg) << CW) + DW'(m0_reg)) << 2;
        p2_next   = (DW'(n1_reg) << CW) + DW'(n0_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= target.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg    <= target.target_x;
            y0_reg    <= target.target_y;
            sqx1_reg  <= BW'(ax0) * BW'(ax0);
            sqy1_reg  <= BW'(ay0) * BW'(ay0);
            x1_reg    <= x0_reg;
            y1_reg    <= y0_reg;
            bb2_reg   <= sqx1_reg + sqy1_reg;
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            sd3_reg   <= sd3_next;
            bb3_reg   <= bb2_reg;
            // partial products, split along the squared distance / cosine
            m0_reg    <= (3*CW-2)'(bb3_reg[CW-1:0]) * (3*CW-2)'(cc_reg);
            m1_reg    <= (3*CW-2)'(bb3_reg[BW-1:CW]) * (3*CW-2)'(cc_reg);
            n0_reg    <= (3*CW)'(sd3_reg.pmag[CW-1:0]) * (3*CW)'(sd3_reg.pmag);
            n1_reg    <= (3*CW)'(sd3_reg.pmag[SW-1:CW]) * (3*CW)'(sd3_reg.pmag);
            sd4_reg   <= sd3_reg;
            four5_reg <= four_next;
            p2_5_reg  <= p2_next;
            sd5_reg   <= sd4_reg;
        end
    end

    // ------------------------------------------------------------------
    // square root row, one root bit per cell
    // ------------------------------------------------------------------
    logic [DW-1:0] sq_rad  [0:SW];
    logic [RW-1:0] sq_rem  [0:SW];
    logic [SW-1:0] sq_root [0:SW];
    side_t         sq_side [0:SW];
    logic          sq_v    [0:SW];
    side_t         sq_side_next;

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_v[0] <= v5_reg;
        end
    end

    // negative area flags the point out of reach
    always_comb
    begin
        sq_side_next         = sd5_reg;
        sq_side_next.unreach = sd5_reg.unreach || (p2_5_reg > four5_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rad[0]  <= four5_reg - p2_5_reg;
            sq_side[0] <= sq_side_next;
        end
    end

    for (genvar k = 0; k < SW; k++)
    begin : g_sqrt
        tlik_sqrt_cell #(
            .SW (SW),
            .DW (DW),
            .RW (RW)
        ) u_cell (
            .clk      (clk),
            .en       (adv),
            .rad_in   (sq_rad[k]),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .rad_out  (sq_rad[k+1]),
            .rem_out  (sq_rem[k+1]),
            .root_out (sq_root[k+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_v[k+1] <= sq_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_side[k+1] <= sq_side[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // normalizer row, brings each pair below 2^31
    // ------------------------------------------------------------------
    logic [SW-1:0] nm_sa   [0:NN];
    logic [SW-1:0] nm_pa   [0:NN];
    logic [SW-1:0] nm_sb   [0:NN];
    logic [SW-1:0] nm_pb   [0:NN];
    nside_t        nm_side [0:NN];
    logic          nm_v    [0:NN];

    assign nm_sa[0]           = sq_root[SW];
    assign nm_pa[0]           = sq_side[SW].pmag;
    assign nm_sb[0]           = sq_root[SW];
    assign nm_pb[0]           = sq_side[SW].qmag;
    assign nm_side[0].unreach = sq_side[SW].unreach;
    assign nm_side[0].x       = sq_side[SW].x;
    assign nm_side[0].y       = sq_side[SW].y;
    assign nm_side[0].pneg    = sq_side[SW].pneg;
    assign nm_side[0].qneg    = sq_side[SW].qneg;
    assign nm_v[0]            = sq_v[SW];

    for (genvar k = 0; k < NN; k++)
    begin : g_norm
        tlik_norm_cell #(
            .SW  (SW),
            .LIM (NB)
        ) u_cell (
            .clk    (clk),
            .en     (adv),
            .sa_in  (nm_sa[k]),
            .pa_in  (nm_pa[k]),
            .sb_in  (nm_sb[k]),
            .pb_in  (nm_pb[k]),
            .sa_out (nm_sa[k+1]),
            .pa_out (nm_pa[k+1]),
            .sb_out (nm_sb[k+1]),
            .pb_out (nm_pb[k+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                nm_v[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                nm_v[k+1] <= nm_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                nm_side[k+1] <= nm_side[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // cordic rows: 0 base angle, 1 alpha, 2 beta
    // ------------------------------------------------------------------
    logic signed [XW-1:0] cd_x   [0:2][0:NC];
    logic signed [XW-1:0] cd_y   [0:2][0:NC];
    logic [TW-1:0]        cd_acc [0:2][0:NC];
    logic                 cd_un  [0:NC];
    logic                 cd_v   [0:NC];

    logic signed [XW-1:0] bx, by, sa_x, pa_x, sb_x, pb_x;
    logic                 base_neg, alpha_neg, beta_neg;

    // half-turn pre-rotation when the x operand is negative; a cosine that
    // normalized to zero counts as non-negative
    always_comb
    begin
        bx        = XW'(nm_side[NN].x);
        by        = XW'(nm_side[NN].y);
        sa_x      = XW'(nm_sa[NN]);
        pa_x      = XW'(nm_pa[NN]);
        sb_x      = XW'(nm_sb[NN]);
        pb_x      = XW'(nm_pb[NN]);
        base_neg  = nm_side[NN].x[CW-1];
        alpha_neg = nm_side[NN].pneg && (nm_pa[NN] != '0);
        beta_neg  = nm_side[NN].qneg && (nm_pb[NN] != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_v[0] <= 1'b0;
        end
        else if (adv)
        begin
            cd_v[0] <= nm_v[NN];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cd_un[0]     <= nm_side[NN].unreach;
            cd_x[0][0]   <= base_neg ? -bx : bx;
            cd_y[0][0]   <= base_neg ? -by : by;
            cd_acc[0][0] <= base_neg ? tlik_pkg::HALF_TURN : '0;
            cd_x[1][0]   <= pa_x;
            cd_y[1][0]   <= alpha_neg ? -sa_x : sa_x;
            cd_acc[1][0] <= alpha_neg ? tlik_pkg::HALF_TURN : '0;
            cd_x[2][0]   <= pb_x;
            cd_y[2][0]   <= beta_neg ? -sb_x : sb_x;
            cd_acc[2][0] <= beta_neg ? tlik_pkg::HALF_TURN : '0;
        end
    end

    for (genvar k = 0; k < NC; k++)
    begin : g_cordic
        for (genvar r = 0; r < 3; r++)
        begin : g_row
            tlik_cordic_cell #(
                .XW  (XW),
                .IDX (k)
            ) u_cell (
                .clk     (clk),
                .en      (adv),
                .x_in    (cd_x[r][k]),
                .y_in    (cd_y[r][k]),
                .acc_in  (cd_acc[r][k]),
                .x_out   (cd_x[r][k+1]),
                .y_out   (cd_y[r][k+1]),
                .acc_out (cd_acc[r][k+1])
            );
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cd_v[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                cd_v[k+1] <= cd_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cd_un[k+1] <= cd_un[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // joint sums, rounding half up to the output angle width
    // ------------------------------------------------------------------
    logic [TW-1:0] shoulder_sum, elbow_sum;
    logic [AW-1:0] shoulder_next, elbow_next;
    logic [AW-1:0] shoulder_reg, elbow_reg;
    logic          unreach_reg;

    always_comb
    begin
        shoulder_sum  = cd_acc[0][NC] - cd_acc[1][NC] + ROUND_HALF;
        elbow_sum     = cd_acc[1][NC] + cd_acc[2][NC] + ROUND_HALF;
        shoulder_next = cd_un[NC] ? '0 : shoulder_sum[TW-1 -: AW];
        elbow_next    = cd_un[NC] ? '0 : elbow_sum[TW-1 -: AW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= cd_v[NC];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            shoulder_reg <= shoulder_next;
            elbow_reg    <= elbow_next;
            unreach_reg  <= cd_un[NC];
        end
    end

    assign joints.valid          = out_valid_reg;
    assign joints.shoulder_angle = shoulder_reg;
    assign joints.elbow_angle    = elbow_reg;
    assign joints.unreachable    = unreach_reg;

endmodule

// ===== hdl/tlik_checker.sv =====
`timescale 1ns / 1ps

module tlik_checker #(
    parameter int AW = tlik_pkg::ANGLE_WIDTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input logic [AW-1:0] shoulder_angle,
    input logic [AW-1:0] elbow_angle,
    input logic          unreachable
);

    // a waiting result is not withdrawn
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before transfer");

    // no result flagged unreachable carries an angle
    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unreachable |-> (shoulder_angle == '0) && (elbow_angle == '0))
        else $error("unreachable result with nonzero angle");

    // a draining output never blocks the input side
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ready || !out_valid) |-> in_ready)
        else $error("input stalled while output drains");

    // leaving reset the pipeline is empty
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present out of reset");

    // output valid stays known after an input transfer
    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$isunknown(out_valid))
        else $error("output valid unknown after transfer");

endmodule

bind two_link_inverse_kinematics tlik_checker #(
    .AW (ANGLE_WIDTH)
) u_tlik_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (target.valid),
    .in_ready       (target.ready),
    .out_valid      (joints.valid),
    .out_ready      (joints.ready),
    .shoulder_angle (joints.shoulder_angle),
    .elbow_angle    (joints.elbow_angle),
    .unreachable    (joints.unreachable)
);
